// ===== rtl/core/binary_min_heap_queue_core_macros.svh =====
// Assertion macros used by the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HMQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HMQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hmq_pkg.sv =====
// Shared opcodes, status codes and control structs of the heap queue.
package hmq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic start;
        logic op;
    } t_eng_req;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_eng_rsp;

endpackage

// ===== rtl/core/hmq_engine.sv =====
// Heap engine: entry memory with two read ports and the sift-up/sift-down sequencer.
module hmq_engine import hmq_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_eng_req                         i_req,
    input  logic [KEY_BITS-1:0]              i_key,
    input  logic [TAG_BITS-1:0]              i_tag,
    output logic                             o_idle,
    output t_eng_rsp                         o_rsp,
    output logic [KEY_BITS-1:0]              o_key,
    output logic [TAG_BITS-1:0]              o_tag,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count,
    input  logic                             i_rsp_ready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int EW = KEY_BITS + TAG_BITS;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CMP  = 3'd1;
    localparam logic [2:0] S_REM_RD   = 3'd2;
    localparam logic [2:0] S_SINK_CMP = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_size, n_size;
    logic [AW-1:0]       r_pos, n_pos;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [KEY_BITS-1:0] r_res_key, n_res_key;
    logic [TAG_BITS-1:0] r_res_tag, n_res_tag;
    t_status             r_res_status, n_res_status;

    logic [EW-1:0]       r_mem [CAPACITY];
    logic [EW-1:0]       r_rd_a, r_rd_b;
    logic [AW-1:0]       rd_addr_a, rd_addr_b;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;

    logic [AW-1:0]       ins_pos, ins_par, par_idx, gp_idx;
    logic [KEY_BITS-1:0] a_key, b_key, min_key;
    logic [TAG_BITS-1:0] a_tag, b_tag;
    logic [IW-1:0]       lc_idx, rc_idx, size_ext, move_idx;
    logic                lt_l, lt_r;
    logic [AW-1:0]       ch_l;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    assign a_key = r_rd_a[EW-1:TAG_BITS];
    assign a_tag = r_rd_a[TAG_BITS-1:0];
    assign b_key = r_rd_b[EW-1:TAG_BITS];
    assign b_tag = r_rd_b[TAG_BITS-1:0];

    assign ins_pos = r_size[AW-1:0];
    assign ins_par = (ins_pos - AW'(1)) >> 1;
    assign par_idx = (r_pos - AW'(1)) >> 1;
    assign gp_idx  = (par_idx - AW'(1)) >> 1;

    // Children of the current slot; the range check against the fill count
    // keeps reads of slots past the end from ever being used.
    assign lc_idx   = IW'({r_pos, 1'b1});
    assign rc_idx   = lc_idx + IW'(1);
    assign size_ext = IW'(r_size);
    assign lt_l     = (lc_idx < size_ext) && (a_key < r_key);
    assign min_key  = lt_l ? a_key : r_key;
    assign lt_r     = (rc_idx < size_ext) && (b_key < min_key);
    assign move_idx = lt_r ? rc_idx : lc_idx;
    assign ch_l     = AW'({move_idx, 1'b1});

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_pos        = r_pos;
        n_key        = r_key;
        n_tag        = r_tag;
        n_res_key    = r_res_key;
        n_res_tag    = r_res_tag;
        n_res_status = r_res_status;
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = {r_key, r_tag};

        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_res_key    = '0;
                    n_res_tag    = '0;
                    n_res_status = ST_DONE;
                    if (i_req.op == OP_INSERT) begin
                        if (r_size < CW'(CAPACITY)) begin
                            n_size    = r_size + CW'(1);
                            n_pos     = ins_pos;
                            n_key     = i_key;
                            n_tag     = i_tag;
                            rd_addr_a = ins_par;
                            n_state   = S_INS_CMP;
                        end else begin
                            n_res_status = ST_FULL;
                            n_state      = S_FIN;
                        end
                    end else begin
                        if (r_size != '0) begin
                            n_size    = r_size - CW'(1);
                            rd_addr_a = '0;
                            rd_addr_b = AW'(r_size - CW'(1));
                            n_state   = S_REM_RD;
                        end else begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_FIN;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                // r_rd_a holds the registered read of the parent of r_pos.
                if ((r_pos != '0) && (r_key < a_key)) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_pos;
                    wr_data   = r_rd_a;
                    n_pos     = par_idx;
                    rd_addr_a = gp_idx;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = {r_key, r_tag};
                    n_state = S_FIN;
                end
            end
            S_REM_RD: begin
                n_res_key = a_key;
                n_res_tag = a_tag;
                n_key     = b_key;
                n_tag     = b_tag;
                n_pos     = '0;
                rd_addr_a = AW'(1);
                rd_addr_b = AW'(2);
                n_state   = (r_size == '0) ? S_FIN : S_SINK_CMP;
            end
            S_SINK_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                if (lt_l || lt_r) begin
                    wr_data   = lt_r ? r_rd_b : r_rd_a;
                    n_pos     = move_idx[AW-1:0];
                    rd_addr_a = ch_l;
                    rd_addr_b = ch_l + AW'(1);
                end else begin
                    wr_data = {r_key, r_tag};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
        end
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_tag        <= n_tag;
        r_res_key    <= n_res_key;
        r_res_tag    <= n_res_tag;
        r_res_status <= n_res_status;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_rsp.valid  = (r_state == S_FIN);
    assign o_rsp.status = r_res_status;
    assign o_key        = r_res_key;
    assign o_tag        = r_res_tag;
    assign o_count      = r_size;

endmodule

// ===== rtl/core/binary_min_heap_queue_core.sv =====
// Top level of the binary min-heap priority queue with its output register.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+----------------------------------------------
//   in      | i_in_valid | o_in_ready  | i_opcode, i_entry_key, i_entry_tag
//   out     | o_out_valid| i_out_ready | o_out_key, o_out_tag, o_status, o_fill_count
//
// One operation is in flight at a time. An insert sifts the new entry up and a remove moves
// the last entry to the root and sifts it down, over at most log2(CAPACITY) levels; a
// refused beat goes to the output register with no sift.
// The sift loop handles one level per cycle on the two read ports and one write port of
// the entry memory. A new beat is taken while the previous result waits in the output
// register. Reset empties the heap at once, with no clearing pass over the memory.
module binary_min_heap_queue_core import hmq_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [KEY_BITS-1:0]           i_entry_key,
    input  logic [TAG_BITS-1:0]           i_entry_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [KEY_BITS-1:0]           o_out_key,
    output logic [TAG_BITS-1:0]           o_out_tag,
    output logic [1:0]                    o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_fill_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_eng_req            eng_req;
    t_eng_rsp            eng_rsp;
    logic                eng_idle;
    logic                rsp_ready;
    logic [KEY_BITS-1:0] eng_key;
    logic [TAG_BITS-1:0] eng_tag;
    logic [CW-1:0]       eng_count;

    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [TAG_BITS-1:0] r_out_tag;
    t_status             r_out_status;
    logic [CW-1:0]       r_out_count;

    assign o_in_ready    = eng_idle;
    assign eng_req.start = i_in_valid && eng_idle;
    assign eng_req.op    = i_opcode;
    assign rsp_ready     = !r_out_valid || i_out_ready;

    hmq_engine #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (eng_req),
        .i_key       (i_entry_key),
        .i_tag       (i_entry_tag),
        .o_idle      (eng_idle),
        .o_rsp       (eng_rsp),
        .o_key       (eng_key),
        .o_tag       (eng_tag),
        .o_count     (eng_count),
        .i_rsp_ready (rsp_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_rsp.valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (eng_rsp.valid && rsp_ready) begin
            r_out_key    <= eng_key;
            r_out_tag    <= eng_tag;
            r_out_status <= eng_rsp.status;
            r_out_count  <= eng_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_tag    = r_out_tag;
    assign o_status     = r_out_status;
    assign o_fill_count = r_out_count;

endmodule

// ===== rtl/core/hmq_checker.sv =====
// Port-level checker for the heap queue, bound to the top level.
`include "binary_min_heap_queue_core_macros.svh"

module hmq_checker import hmq_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 9
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [KEY_BITS-1:0]           o_out_key,
    input logic [TAG_BITS-1:0]           o_out_tag,
    input logic [1:0]                    o_status,
    input logic [$clog2(CAPACITY+1)-1:0] o_fill_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    // A refused insert only happens with the heap at capacity.
    `HMQ_ASSERT_IMP(a_full_count, o_out_valid && (o_status == ST_FULL), (o_fill_count == CW'(CAPACITY)) && (o_out_key == '0) && (o_out_tag == '0), "full beat with wrong count or payload")

    // A refused remove only happens with the heap empty.
    `HMQ_ASSERT_IMP(a_empty_count, o_out_valid && (o_status == ST_EMPTY), (o_fill_count == '0) && (o_out_key == '0) && (o_out_tag == '0), "empty beat with wrong count or payload")

    // Operations run one at a time, so an accepted beat closes the input.
    `HMQ_ASSERT_NXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "input still open after a beat was taken")

    `HMQ_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_key) && $stable(o_out_tag) && $stable(o_status) && $stable(o_fill_count), "stalled result beat changed")

endmodule

bind binary_min_heap_queue_core hmq_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_hmq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_key    (o_out_key),
    .o_out_tag    (o_out_tag),
    .o_status     (o_status),
    .o_fill_count (o_fill_count)
);

// ===== tb/binary_min_heap_queue_core_test.sv =====
// Self-checking testbench for the binary min-heap priority queue core.
module binary_min_heap_queue_core_test;
    import hmq_pkg::*;

    localparam int CAPACITY    = 256;
    localparam int KEY_BITS    = 32;
    localparam int TAG_BITS    = 9;
    localparam int FILL_BITS   = $clog2(CAPACITY + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [KEY_BITS-1:0]  key;
        logic [TAG_BITS-1:0]  tag;
        t_status              status;
        logic [FILL_BITS-1:0] fill;
    } t_heap_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_opcode = OP_INSERT;
    logic [KEY_BITS-1:0]  i_entry_key = '0;
    logic [TAG_BITS-1:0]  i_entry_tag = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [KEY_BITS-1:0]  o_out_key;
    logic [TAG_BITS-1:0]  o_out_tag;
    logic [1:0]           o_status;
    logic [FILL_BITS-1:0] o_fill_count;

    // Shadow copy of the heap, updated when each beat is accepted.
    logic [KEY_BITS-1:0] heap_key_mem [CAPACITY];
    logic [TAG_BITS-1:0] heap_tag_mem [CAPACITY];
    int                  heap_count = 0;

    t_heap_result pending_heap_results [$];

    int  failure_count = 0;
    int  inserts_done = 0;
    int  inserts_refused = 0;
    int  removes_done = 0;
    int  removes_refused = 0;
    int  peak_fill = 0;
    int  results_checked = 0;
    bit  quiet_mode = 1'b0;
    int  ready_hold_request = 0;

    binary_min_heap_queue_core #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS),
        .TAG_BITS(TAG_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_opcode(i_opcode),
        .i_entry_key(i_entry_key),
        .i_entry_tag(i_entry_tag),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_key(o_out_key),
        .o_out_tag(o_out_tag),
        .o_status(o_status),
        .o_fill_count(o_fill_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_heap_result apply_heap_op(input logic op,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [TAG_BITS-1:0] tag);
        t_heap_result        res;
        int                  pos;
        int                  up;
        int                  best;
        int                  lc;
        int                  rc;
        logic [KEY_BITS-1:0] tmp_key;
        logic [TAG_BITS-1:0] tmp_tag;
        res.key = '0;
        res.tag = '0;
        res.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = ST_FULL;
                inserts_refused++;
            end else begin
                pos = heap_count;
                heap_count++;
                // Sift up while strictly smaller than the parent.
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (!(key < heap_key_mem[up]))
                        break;
                    heap_key_mem[pos] = heap_key_mem[up];
                    heap_tag_mem[pos] = heap_tag_mem[up];
                    pos = up;
                end
                heap_key_mem[pos] = key;
                heap_tag_mem[pos] = tag;
                inserts_done++;
            end
        end else begin
            if (heap_count == 0) begin
                res.status = ST_EMPTY;
                removes_refused++;
            end else begin
                res.key = heap_key_mem[0];
                res.tag = heap_tag_mem[0];
                heap_key_mem[0] = heap_key_mem[heap_count - 1];
                heap_tag_mem[0] = heap_tag_mem[heap_count - 1];
                heap_count--;
                pos = 0;
                // Left child is tried first, then the right, both strict.
                forever begin
                    best = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < heap_count && heap_key_mem[lc] < heap_key_mem[best])
                        best = lc;
                    if (rc < heap_count && heap_key_mem[rc] < heap_key_mem[best])
                        best = rc;
                    if (best == pos)
                        break;
                    tmp_key = heap_key_mem[pos];
                    tmp_tag = heap_tag_mem[pos];
                    heap_key_mem[pos] = heap_key_mem[best];
                    heap_tag_mem[pos] = heap_tag_mem[best];
                    heap_key_mem[best] = tmp_key;
                    heap_tag_mem[best] = tmp_tag;
                    pos = best;
                end
                removes_done++;
            end
        end
        if (heap_count > peak_fill)
            peak_fill = heap_count;
        res.fill = heap_count[FILL_BITS-1:0];
        return res;
    endfunction

    // Small keys give plenty of ties; the rest are extremes or full range.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return KEY_BITS'($urandom_range(15));
        if (sel == 4)
            return $urandom_range(1) ? '1 : '0;
        return KEY_BITS'($urandom);
    endfunction

    function automatic void note_failure(input string what);
        failure_count++;
        if (failure_count <= REPORT_MAX)
            $display("%0t: %s", $time, what);
    endfunction

    // Offers one beat and returns at the edge that accepts it; valid stays high
    // so that a following beat can go out back to back.
    task automatic send_heap_op(input logic op, input logic [KEY_BITS-1:0] key,
                                input logic [TAG_BITS-1:0] tag);
        while (!quiet_mode && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_entry_key <= key;
        i_entry_tag <= tag;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        pending_heap_results.push_back(apply_heap_op(op, key, tag));
    endtask

    task automatic send_random_op();
        logic op;
        if (heap_count < 16)
            op = ($urandom_range(99) < 70) ? OP_INSERT : OP_REMOVE;
        else
            op = $urandom_range(1) ? OP_INSERT : OP_REMOVE;
        send_heap_op(op, pick_key(), TAG_BITS'($urandom_range(511)));
    endtask

    task automatic test_directed_cases();
        send_heap_op(OP_REMOVE, pick_key(), TAG_BITS'($urandom));
        send_heap_op(OP_INSERT, 32'h8000_0000, 9'h100);
        send_heap_op(OP_INSERT, 32'hFFFF_FFFF, 9'h1FF);
        send_heap_op(OP_INSERT, 32'h0000_0000, 9'h000);
        // Equal keys check the exact tie order of the sift.
        send_heap_op(OP_INSERT, 32'd5, 9'h0AA);
        send_heap_op(OP_INSERT, 32'd5, 9'h155);
        send_heap_op(OP_INSERT, 32'd5, 9'h003);
        send_heap_op(OP_INSERT, 32'h5555_5555, 9'h0FF);
        send_heap_op(OP_INSERT, 32'hAAAA_AAAA, 9'h001);
        repeat (9)
            send_heap_op(OP_REMOVE, pick_key(), TAG_BITS'($urandom));
        send_heap_op(OP_INSERT, 32'h0000_0001, 9'h0F0);
        send_heap_op(OP_REMOVE, 32'hFFFF_FFFF, 9'h1FF);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_random_op();
    endtask

    task automatic test_streaming();
        quiet_mode = 1'b1;
        repeat (100)
            send_random_op();
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        // The receiver sits out a long stretch while beats keep coming.
        ready_hold_request = 300;
        repeat (40)
            send_random_op();
    endtask

    task automatic test_full_and_drain();
        while (heap_count < CAPACITY)
            send_heap_op(OP_INSERT, pick_key(), TAG_BITS'($urandom));
        repeat (4)
            send_heap_op(OP_INSERT, pick_key(), TAG_BITS'($urandom));
        repeat (3) begin
            send_heap_op(OP_REMOVE, pick_key(), TAG_BITS'($urandom));
            send_heap_op(OP_INSERT, pick_key(), TAG_BITS'($urandom));
        end
        while (heap_count > 0)
            send_heap_op(OP_REMOVE, pick_key(), TAG_BITS'($urandom));
        repeat (2)
            send_heap_op(OP_REMOVE, pick_key(), TAG_BITS'($urandom));
    endtask

    // Result checker and receiver-side flow control.
    always @(posedge i_clk) begin
        static int    hold_left = 0;
        t_heap_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_checked++;
            if (pending_heap_results.size() == 0) begin
                note_failure($sformatf("result beat with nothing outstanding: key %h tag %h",
                                       o_out_key, o_out_tag));
            end else begin
                want = pending_heap_results.pop_front();
                if (o_out_key !== want.key)
                    note_failure($sformatf("out_key: expected %h, got %h", want.key, o_out_key));
                if (o_out_tag !== want.tag)
                    note_failure($sformatf("out_tag: expected %h, got %h", want.tag, o_out_tag));
                if (o_status !== want.status)
                    note_failure($sformatf("status: expected %0d, got %0d",
                                           want.status, o_status));
                if (o_fill_count !== want.fill)
                    note_failure($sformatf("fill_count: expected %0d, got %0d",
                                           want.fill, o_fill_count));
            end
        end
        if (ready_hold_request > 0) begin
            hold_left = ready_hold_request;
            ready_hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_mode || ($urandom_range(99) >= 11);
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (10)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic(300);
        test_streaming();
        test_backpressure();
        test_full_and_drain();
        test_random_traffic(60);
        i_in_valid <= 1'b0;
        while (pending_heap_results.size() != 0)
            @(posedge i_clk);
        repeat (30)
            @(posedge i_clk);
        $display("Checked %0d results: %0d inserts, %0d removes, peak fill %0d.",
                 results_checked, inserts_done, removes_done, peak_fill);
        $display("Refused beats: %0d inserts on a full heap, %0d removes on an empty one.",
                 inserts_refused, removes_refused);
        if (failure_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", failure_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
